/* src/e2q_pkg.sv */
// Shared types, constants and arithmetic helpers for the Euler angle to quaternion unit.
// Used by every module of the block; it depends on nothing else.
`default_nettype none
package e2q_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int ANG_SHIFT      = 33 - ANGLE_BITS;
  localparam int RND_SHIFT      = 30 - QUAT_FRAC_BITS;
  localparam int WW             = QUAT_FRAC_BITS + 1;
  localparam int CW             = QUAT_FRAC_BITS + 2;
  localparam int ZW             = 34;
  localparam int SCW            = 32;
  localparam int RW             = 64;
  localparam int ROOTW          = 33;
  localparam int BIGW           = 32;
  localparam int CORDIC_STEPS   = 30;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 31;

  localparam logic signed [ZW-1:0]  PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [SCW-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

  typedef logic [4:0] step_idx_t;

  typedef enum logic [1:0] {
    BR_TRACE,
    BR_XX,
    BR_YY,
    BR_ZZ
  } branch_t;

  typedef struct packed {
    logic                  vld;
    logic [2:0]            flip;
    logic [2:0][SCW-1:0]   x;
    logic [2:0][SCW-1:0]   y;
    logic [2:0][ZW-1:0]    z;
  } cordic_t;

  typedef struct packed {
    logic                  vld;
    logic [2:0][SCW-1:0]   sn;
    logic [2:0][SCW-1:0]   cs;
  } trig_t;

  typedef struct packed {
    logic                  vld;
    branch_t               br;
    logic [2:0][ZW-1:0]    num;
    logic [RW-1:0]         rad;
    logic [RW-1:0]         root;
  } sqrt_t;

  typedef struct packed {
    logic                      vld;
    branch_t                   br;
    logic [BIGW-1:0]           big;
    logic [ZW-1:0]             dvs;
    logic                      dz;
    logic [2:0]                neg;
    logic [2:0]                ovf;
    logic [2:0][RW-1:0]        rem;
    logic [2:0][DIV_STEPS-1:0] quo;
  } div_t;

  function automatic logic signed [ZW-1:0] atan_entry(input step_idx_t i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:    r = 34'sh03243F6A8;
      5'd1:    r = 34'sh01DAC6705;
      5'd2:    r = 34'sh00FADBAFC;
      5'd3:    r = 34'sh007F56EA6;
      5'd4:    r = 34'sh003FEAB76;
      5'd5:    r = 34'sh001FFD55B;
      5'd6:    r = 34'sh000FFFAAA;
      5'd7:    r = 34'sh0007FFF55;
      5'd8:    r = 34'sh0003FFFEA;
      5'd9:    r = 34'sh0001FFFFD;
      default: r = (ZW'(1) << (5'd30 - i)) - ZW'(1);
    endcase
    return r;
  endfunction

  // Product of two Q30 values, floored back to Q30.
  function automatic logic signed [SCW-1:0] mulq(input logic signed [SCW-1:0] a,
                                                 input logic signed [SCW-1:0] b);
    logic signed [2*SCW-1:0] p;
    p = a * b;
    return p[SCW+29:30];
  endfunction

endpackage
`default_nettype wire

/* src/e2q_cordic_cell.sv */
// One rotation-mode CORDIC iteration for all three angles, registered.
// Depends on e2q_pkg for the data record and the arctangent table.
`default_nettype none
module e2q_cordic_cell import e2q_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  step_idx_t idx,
  input  cordic_t   d_in,
  output cordic_t   d_out
);

  cordic_t cell_r;
  cordic_t cell_nxt;

  always_comb begin
    logic signed [SCW-1:0] dx;
    logic signed [SCW-1:0] dy;
    logic signed [ZW-1:0]  at;
    cell_nxt = d_in;
    at = atan_entry(idx);
    for (int k = 0; k < 3; k++) begin
      dx = $signed(d_in.y[k]) >>> idx;
      dy = $signed(d_in.x[k]) >>> idx;
      if (!d_in.z[k][ZW-1]) begin
        cell_nxt.x[k] = d_in.x[k] - dx;
        cell_nxt.y[k] = d_in.y[k] + dy;
        cell_nxt.z[k] = d_in.z[k] - at;
      end else begin
        cell_nxt.x[k] = d_in.x[k] + dx;
        cell_nxt.y[k] = d_in.y[k] - dy;
        cell_nxt.z[k] = d_in.z[k] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

/* src/e2q_sqrt_cell.sv */
// One digit step of the integer square root, registered, carrying the quotient numerators.
// Depends on e2q_pkg for the data record.
`default_nettype none
module e2q_sqrt_cell import e2q_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  step_idx_t idx,
  input  sqrt_t     d_in,
  output sqrt_t     d_out
);

  sqrt_t cell_r;
  sqrt_t cell_nxt;

  always_comb begin
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    cell_nxt = d_in;
    bitv  = RW'(1) << (6'd62 - {idx, 1'b0});
    trial = d_in.root + bitv;
    if (d_in.rad >= trial) begin
      cell_nxt.rad  = d_in.rad - trial;
      cell_nxt.root = (d_in.root >> 1) + bitv;
    end else begin
      cell_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

/* src/e2q_div_cell.sv */
// One quotient bit of the three restoring divisions, registered.
// Depends on e2q_pkg for the data record.
`default_nettype none
module e2q_div_cell import e2q_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  step_idx_t idx,
  input  div_t      d_in,
  output div_t      d_out
);

  div_t cell_r;
  div_t cell_nxt;

  always_comb begin
    logic [RW-1:0] trial;
    cell_nxt = d_in;
    trial = RW'(d_in.dvs) << idx;
    for (int k = 0; k < 3; k++) begin
      if (d_in.rem[k] >= trial) begin
        cell_nxt.rem[k]      = d_in.rem[k] - trial;
        cell_nxt.quo[k][idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

/* src/e2q_matrix.sv */
// Rotation matrix from sines and cosines, then branch choice and square-root radicand.
// Three register stages; depends on e2q_pkg for records, branch codes and mulq.
`default_nettype none
module e2q_matrix import e2q_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  trig_t d_in,
  output sqrt_t d_out
);

  typedef struct packed {
    logic                 vld;
    logic [10:0][SCW-1:0] p;
    logic [SCW-1:0]       sph;
    logic [SCW-1:0]       sth;
    logic [SCW-1:0]       sps;
  } prod_t;

  typedef struct packed {
    logic                vld;
    logic [8:0][ZW-1:0]  r;
  } rot_t;

  prod_t prod_r, prod_nxt;
  rot_t  rot_r, rot_nxt;
  sqrt_t rad_r, rad_nxt;

  always_comb begin
    logic signed [SCW-1:0] sph, cph, sth, cth, sps, cps;
    sph = $signed(d_in.sn[0]);
    cph = $signed(d_in.cs[0]);
    sth = $signed(d_in.sn[1]);
    cth = $signed(d_in.cs[1]);
    sps = $signed(d_in.sn[2]);
    cps = $signed(d_in.cs[2]);
    prod_nxt.vld   = d_in.vld;
    prod_nxt.p[0]  = mulq(cps, cth);
    prod_nxt.p[1]  = mulq(sph, sps);
    prod_nxt.p[2]  = mulq(cth, sps);
    prod_nxt.p[3]  = mulq(cps, sph);
    prod_nxt.p[4]  = mulq(cph, sth);
    prod_nxt.p[5]  = mulq(cph, sps);
    prod_nxt.p[6]  = mulq(cph, cps);
    prod_nxt.p[7]  = mulq(cps, sth);
    prod_nxt.p[8]  = mulq(cth, sph);
    prod_nxt.p[9]  = mulq(sps, sth);
    prod_nxt.p[10] = mulq(cph, cth);
    prod_nxt.sph   = sph;
    prod_nxt.sth   = sth;
    prod_nxt.sps   = sps;
  end

  always_comb begin
    logic signed [SCW-1:0] t00, t01, t20, t21;
    t00 = mulq($signed(prod_r.p[1]), $signed(prod_r.sth));
    t01 = mulq($signed(prod_r.p[3]), $signed(prod_r.sth));
    t20 = mulq($signed(prod_r.p[8]), $signed(prod_r.sps));
    t21 = mulq($signed(prod_r.p[0]), $signed(prod_r.sph));
    rot_nxt.vld  = prod_r.vld;
    rot_nxt.r[0] = ZW'($signed(prod_r.p[0])) - ZW'(t00);
    rot_nxt.r[1] = ZW'($signed(prod_r.p[2])) + ZW'(t01);
    rot_nxt.r[2] = -ZW'($signed(prod_r.p[4]));
    rot_nxt.r[3] = -ZW'($signed(prod_r.p[5]));
    rot_nxt.r[4] = ZW'($signed(prod_r.p[6]));
    rot_nxt.r[5] = ZW'($signed(prod_r.sph));
    rot_nxt.r[6] = ZW'($signed(prod_r.p[7])) + ZW'(t20);
    rot_nxt.r[7] = ZW'($signed(prod_r.p[9])) - ZW'(t21);
    rot_nxt.r[8] = ZW'($signed(prod_r.p[10]));
  end

  always_comb begin
    logic signed [ZW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic signed [ZW-1:0] tr, v, na, nb, nc, nd, ne, nf;
    r00 = $signed(rot_r.r[0]);
    r01 = $signed(rot_r.r[1]);
    r02 = $signed(rot_r.r[2]);
    r10 = $signed(rot_r.r[3]);
    r11 = $signed(rot_r.r[4]);
    r12 = $signed(rot_r.r[5]);
    r20 = $signed(rot_r.r[6]);
    r21 = $signed(rot_r.r[7]);
    r22 = $signed(rot_r.r[8]);
    tr = r00 + r11 + r22;
    na = r21 - r12;
    nb = r02 - r20;
    nc = r10 - r01;
    nd = r01 + r10;
    ne = r02 + r20;
    nf = r12 + r21;
    rad_nxt.vld  = rot_r.vld;
    rad_nxt.root = '0;
    if (tr > 0) begin
      rad_nxt.br  = BR_TRACE;
      v = (ZW'(1) << 30) + tr;
      rad_nxt.num = {nc, nb, na};
    end else if (r00 > r11 && r00 > r22) begin
      rad_nxt.br  = BR_XX;
      v = (ZW'(1) << 30) + r00 - r11 - r22;
      rad_nxt.num = {ne, nd, na};
    end else if (r11 > r22) begin
      rad_nxt.br  = BR_YY;
      v = (ZW'(1) << 30) + r11 - r00 - r22;
      rad_nxt.num = {nf, nd, nb};
    end else begin
      rad_nxt.br  = BR_ZZ;
      v = (ZW'(1) << 30) + r22 - r00 - r11;
      rad_nxt.num = {nf, ne, nc};
    end
    rad_nxt.rad = v[ZW-1] ? '0 : RW'({v[ZW-2:0], 30'd0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.vld <= 1'b0;
      rot_r.vld  <= 1'b0;
      rad_r.vld  <= 1'b0;
    end else if (en) begin
      prod_r <= prod_nxt;
      rot_r  <= rot_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign d_out = rad_r;

endmodule
`default_nettype wire

/* src/euler_to_quaternion_unit.sv */
// Euler angle to unit quaternion converter: top level with the cell chains and output buffer.
// Depends on e2q_pkg, e2q_cordic_cell, e2q_matrix, e2q_sqrt_cell and e2q_div_cell.
//
// Usage: an angle triple (phi, theta, psi, radians times 8192) is offered on the in_ channel
// with valid and ready; each accepted transaction yields exactly one quaternion transaction
// on the out_ channel, w never negative, all parts times 16384, in order of acceptance.
// From acceptance to out_valid a transaction passes one angle reduction stage, 30 CORDIC
// cells, one sign stage, three matrix stages, 32 square-root cells, one divider set-up stage,
// 31 divider cells and the output register. Throughput is one transaction per cycle while
// the skid buffer is empty; the stages ahead of the output register advance as one chain.
// The output register is backed by a one-entry skid buffer, so the chain keeps accepting while
// a result waits. When the receiver stalls the buffer fills, in_ready falls and the whole chain
// holds until the waiting result is taken. After a synchronous reset every stage is empty and
// in_ready is high in the first cycle.
`default_nettype none
module euler_to_quaternion_unit import e2q_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] in_phi_angle,
  input  logic signed [ANGLE_BITS-1:0] in_theta_angle,
  input  logic signed [ANGLE_BITS-1:0] in_psi_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [WW-1:0]                out_w_component,
  output logic signed [CW-1:0]         out_x_component,
  output logic signed [CW-1:0]         out_y_component,
  output logic signed [CW-1:0]         out_z_component
);

  typedef struct packed {
    logic [WW-1:0] w;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } quat_t;

  logic    en;
  cordic_t ang_r, ang_nxt;
  cordic_t cord [CORDIC_STEPS+1];
  trig_t   trig_r, trig_nxt;
  sqrt_t   sq [SQRT_STEPS+1];
  div_t    dsu_r, dsu_nxt;
  div_t    dv [DIV_STEPS+1];
  quat_t   res;
  logic    out_vld_r, out_vld_nxt;
  quat_t   out_r, out_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  quat_t   skid_r, skid_nxt;
  logic    produce;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  always_comb begin
    logic signed [ANGLE_BITS-1:0] ang [3];
    logic signed [ZW-1:0]         za;
    ang[0] = in_phi_angle;
    ang[1] = in_theta_angle;
    ang[2] = in_psi_angle;
    ang_nxt.vld = in_valid;
    for (int k = 0; k < 3; k++) begin
      za = ZW'(ang[k]) <<< ANG_SHIFT;
      ang_nxt.flip[k] = 1'b0;
      if (za > HALF_PI_Q30) begin
        za = za - PI_Q30;
        ang_nxt.flip[k] = 1'b1;
      end else if (za < -HALF_PI_Q30) begin
        za = za + PI_Q30;
        ang_nxt.flip[k] = 1'b1;
      end
      ang_nxt.x[k] = CORDIC_GAIN;
      ang_nxt.y[k] = '0;
      ang_nxt.z[k] = za;
    end
  end

  assign cord[0] = ang_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    e2q_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (step_idx_t'(i)),
      .d_in  (cord[i]),
      .d_out (cord[i+1])
    );
  end

  always_comb begin
    trig_nxt.vld = cord[CORDIC_STEPS].vld;
    for (int k = 0; k < 3; k++) begin
      trig_nxt.sn[k] = cord[CORDIC_STEPS].flip[k] ? -cord[CORDIC_STEPS].y[k]
                                                  : cord[CORDIC_STEPS].y[k];
      trig_nxt.cs[k] = cord[CORDIC_STEPS].flip[k] ? -cord[CORDIC_STEPS].x[k]
                                                  : cord[CORDIC_STEPS].x[k];
    end
  end

  e2q_matrix u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  (trig_r),
    .d_out (sq[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    e2q_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (step_idx_t'(i)),
      .d_in  (sq[i]),
      .d_out (sq[i+1])
    );
  end

  always_comb begin
    logic [ROOTW-1:0]     root;
    logic [ZW-1:0]        dvs;
    logic signed [ZW-1:0] n;
    logic [ZW-1:0]        mag;
    root = sq[SQRT_STEPS].root[ROOTW-1:0];
    dvs  = ZW'({root, 1'b0});
    dsu_nxt.vld = sq[SQRT_STEPS].vld;
    dsu_nxt.br  = sq[SQRT_STEPS].br;
    dsu_nxt.big = root[ROOTW-1:1];
    dsu_nxt.dvs = dvs;
    dsu_nxt.dz  = (dvs == '0);
    dsu_nxt.quo = '0;
    for (int k = 0; k < 3; k++) begin
      n   = $signed(sq[SQRT_STEPS].num[k]);
      mag = n[ZW-1] ? -n : n;
      dsu_nxt.neg[k] = n[ZW-1];
      // A quotient of 2^31 or more saturates its own output component, so it is only flagged.
      dsu_nxt.ovf[k] = (dvs != '0) && ({1'b0, mag} >= {dvs, 1'b0});
      dsu_nxt.rem[k] = RW'({mag, 30'd0});
    end
  end

  assign dv[0] = dsu_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    e2q_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .idx   (step_idx_t'(DIV_STEPS - 1 - i)),
      .d_in  (dv[i]),
      .d_out (dv[i+1])
    );
  end

  function automatic logic signed [ZW-1:0] round_sat(input logic signed [ZW-1:0] v,
                                                     input logic signed [ZW-1:0] lo);
    logic signed [ZW-1:0] r;
    logic signed [ZW-1:0] hi;
    hi = ZW'(1) << QUAT_FRAC_BITS;
    r  = (v + (ZW'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  always_comb begin
    logic [SCW-1:0]       qm;
    logic signed [ZW-1:0] q [3];
    logic signed [ZW-1:0] bg;
    logic signed [ZW-1:0] w, x, y, z;
    logic signed [ZW-1:0] wr, xr, yr, zr;
    for (int k = 0; k < 3; k++) begin
      if (dv[DIV_STEPS].dz) qm = '0;
      else if (dv[DIV_STEPS].ovf[k]) qm = SCW'(1) << (SCW - 1);
      else qm = SCW'(dv[DIV_STEPS].quo[k]);
      q[k] = dv[DIV_STEPS].neg[k] ? -ZW'(qm) : ZW'(qm);
    end
    bg = ZW'(dv[DIV_STEPS].big);
    case (dv[DIV_STEPS].br)
      BR_TRACE: begin w = bg;   x = q[0]; y = q[1]; z = q[2]; end
      BR_XX:    begin w = q[0]; x = bg;   y = q[1]; z = q[2]; end
      BR_YY:    begin w = q[0]; x = q[1]; y = bg;   z = q[2]; end
      default:  begin w = q[0]; x = q[1]; y = q[2]; z = bg;   end
    endcase
    if (w < 0) begin
      w = -w;
      x = -x;
      y = -y;
      z = -z;
    end
    wr = round_sat(w, '0);
    xr = round_sat(x, -(ZW'(1) << QUAT_FRAC_BITS));
    yr = round_sat(y, -(ZW'(1) << QUAT_FRAC_BITS));
    zr = round_sat(z, -(ZW'(1) << QUAT_FRAC_BITS));
    res.w = wr[WW-1:0];
    res.x = xr[CW-1:0];
    res.y = yr[CW-1:0];
    res.z = zr[CW-1:0];
  end

  assign produce = en && dv[DIV_STEPS].vld;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = produce;
        out_nxt     = res;
      end
    end else if (produce) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r.vld  <= 1'b0;
      trig_r.vld <= 1'b0;
      dsu_r.vld  <= 1'b0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (en) begin
        ang_r  <= ang_nxt;
        trig_r <= trig_nxt;
        dsu_r  <= dsu_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_w_component = out_r.w;
  assign out_x_component = out_r.x;
  assign out_y_component = out_r.y;
  assign out_z_component = out_r.z;

endmodule
`default_nettype wire
